@@ hdl/lru_set_assoc_cache_model_top_defines.svh @@
// Assertion macros for the checker of the LRU cache model block.
// No dependencies; include by bare file name where assertions are written.
`ifndef LRU_SET_ASSOC_CACHE_MODEL_TOP_DEFINES_SVH
`define LRU_SET_ASSOC_CACHE_MODEL_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LRU_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lru checker: same-cycle rule violated");

// Next-cycle implication, disabled while reset is asserted.
`define LRU_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lru checker: next-cycle rule violated");

`endif

@@ hdl/lru_pkg.sv @@
// Package for the LRU set-associative cache model: sizes, register codes,
// payload and memory row types. No dependencies.
`timescale 1ns / 1ps

package lru_pkg;

    localparam int MAX_SET_BITS = 6;
    localparam int MAX_WAYS     = 8;
    localparam int ADDR_BITS    = 64;

    localparam int NUM_SETS        = 1 << MAX_SET_BITS;
    localparam int SET_W           = (MAX_SET_BITS > 0) ? MAX_SET_BITS : 1;
    localparam int WAY_W           = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int WCNT_W          = $clog2(MAX_WAYS + 1);
    localparam int MAX_OFFSET_BITS = 32;
    localparam int TAG_W           = ADDR_BITS;

    localparam logic [ADDR_BITS-1:0] ADDR_MASK = '1;

    // Configuration register fields and codes
    localparam int CFG_SET_W  = 3;
    localparam int CFG_WAYS_W = 4;
    localparam int CFG_OFF_W  = 6;
    localparam int CFG_DATA_W = 6;
    localparam int CFG_IDX_W  = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_SET_INDEX_BITS    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_OFFSET_BITS = 2'd2;

    // Access commands
    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_STORE  = 2'd1;
    localparam logic [1:0] CMD_MODIFY = 2'd2;
    localparam logic [1:0] CMD_FETCH  = 2'd3;

    typedef struct packed {
        logic [1:0]          command;
        logic [63:0]         address;
    } t_in;

    typedef struct packed {
        logic        was_hit;
        logic        was_miss;
        logic        was_eviction;
        logic        modify_write_hit;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] eviction_total;
    } t_out;

    // One set: tags and line valid bits, way 0 is the most recent line
    typedef struct packed {
        logic [MAX_WAYS-1:0][TAG_W-1:0] tags;
        logic [MAX_WAYS-1:0]            vld;
    } t_row;

endpackage

@@ hdl/lru_set_assoc_cache_model_top.sv @@
// LRU set-associative cache model (tags only), top level; depends on lru_pkg.
// An accepted transaction reads its set row in IDLE; LOOK writes the row back
//   and loads the result register. No new transaction is taken before LOOK
//   is left, and LOOK holds while the previous result waits downstream.
// Reset (synchronous, active low): counters zero, all sets empty, registers
//   back to 0 sets bits / 1 way / 0 offset bits; no clearing pass is needed.
`timescale 1ns / 1ps

module lru_set_assoc_cache_model_top
    import lru_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // Access channel
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  t_in                   i_in_data,
    // Result channel
    output logic                  o_out_valid,
    input  logic                  i_out_ready,
    output t_out                  o_out_data,
    // Configuration write port
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_LOOK = 1'b1;

    function automatic logic [31:0] sat_inc(input logic [31:0] v, input logic en);
        sat_inc = (en && (v != '1)) ? v + 32'd1 : v;
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [CFG_SET_W-1:0]  r_cfg_set;
    logic [CFG_WAYS_W-1:0] r_cfg_ways;
    logic [CFG_OFF_W-1:0]  r_cfg_off;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_set  <= '0;
            r_cfg_ways <= CFG_WAYS_W'(1);
            r_cfg_off  <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_SET_INDEX_BITS:    r_cfg_set  <= i_cfg_data[CFG_SET_W-1:0];
                CFG_WAYS_IN_USE:       r_cfg_ways <= i_cfg_data[CFG_WAYS_W-1:0];
                CFG_BLOCK_OFFSET_BITS: r_cfg_off  <= i_cfg_data[CFG_OFF_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp the registers to the supported ranges
    logic [CFG_SET_W-1:0] w_sbits;
    logic [CFG_OFF_W-1:0] w_obits;
    logic [WCNT_W-1:0]    w_ways;
    logic [WAY_W-1:0]     w_last_way;
    logic [CFG_OFF_W:0]   w_tag_shift;

    always_comb begin
        w_sbits = (int'(r_cfg_set) > MAX_SET_BITS) ? CFG_SET_W'(MAX_SET_BITS) : r_cfg_set;
        w_obits = (int'(r_cfg_off) > MAX_OFFSET_BITS) ? CFG_OFF_W'(MAX_OFFSET_BITS)
                                                       : r_cfg_off;
        if (r_cfg_ways == '0) begin
            w_ways = WCNT_W'(1);
        end else if (int'(r_cfg_ways) > MAX_WAYS) begin
            w_ways = WCNT_W'(MAX_WAYS);
        end else begin
            w_ways = WCNT_W'(r_cfg_ways);
        end
        w_last_way  = WAY_W'(w_ways - WCNT_W'(1));
        w_tag_shift = {1'b0, w_obits} + (CFG_OFF_W + 1)'(w_sbits);
    end

    // ------------------------------------------------------------------
    // Address split at accept time
    // ------------------------------------------------------------------
    logic [ADDR_BITS-1:0] w_addr;
    logic [ADDR_BITS-1:0] w_set_mask;
    logic [ADDR_BITS-1:0] w_set_full;
    logic [SET_W-1:0]     w_set;
    logic [TAG_W-1:0]     w_tag;

    always_comb begin
        w_addr     = i_in_data.address[ADDR_BITS-1:0] & ADDR_MASK;
        w_set_mask = (ADDR_BITS'(1) << w_sbits) - ADDR_BITS'(1);
        w_set_full = (w_addr >> w_obits) & w_set_mask;
        w_set      = w_set_full[SET_W-1:0];
        w_tag      = TAG_W'(w_addr >> w_tag_shift);
    end

    // ------------------------------------------------------------------
    // Control: IDLE takes a transaction and reads its set, LOOK compares,
    // reorders, writes the row back unless the command is a fetch, and loads the result register.
    // ------------------------------------------------------------------
    logic             r_state;
    logic             n_state;
    logic [1:0]       r_cmd;
    logic [SET_W-1:0] r_set;
    logic [TAG_W-1:0] r_tag;

    logic w_accept;
    logic w_out_free;
    logic w_finish;
    logic w_mem_we;

    assign o_in_ready = (r_state == ST_IDLE);
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_out_free = !o_out_valid || i_out_ready;
    // Hold in LOOK while the previous result still waits downstream
    assign w_finish   = (r_state == ST_LOOK) && w_out_free;
    assign w_mem_we   = w_finish && (r_cmd != CMD_FETCH);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: if (w_accept) n_state = ST_LOOK;
            ST_LOOK: if (w_out_free) n_state = ST_IDLE;
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_cmd <= i_in_data.command;
            r_set <= w_set;
            r_tag <= w_tag;
        end
    end

    // ------------------------------------------------------------------
    // Set memory and per-row occupancy flags. A row whose flag is clear
    // reads as all lines invalid, so reset needs no sweep of the memory.
    // ------------------------------------------------------------------
    t_row                mem [NUM_SETS];
    logic [NUM_SETS-1:0] r_row_used;
    t_row                r_rd_row;
    logic                r_rd_used;
    t_row                w_wr_row;

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            mem[r_set] <= w_wr_row;
        end
        if (w_accept) begin
            r_rd_row <= mem[w_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_used <= '0;
            r_rd_used  <= 1'b0;
        end else begin
            if (w_mem_we) begin
                r_row_used[r_set] <= 1'b1;
            end
            if (w_accept) begin
                r_rd_used <= r_row_used[w_set];
            end
        end
    end

    // ------------------------------------------------------------------
    // Lookup and move-to-front
    // ------------------------------------------------------------------
    logic [MAX_WAYS-1:0] w_vld;
    logic                w_hit;
    logic [WAY_W-1:0]    w_hit_pos;
    logic [WAY_W-1:0]    w_pos;
    logic                w_evict;
    logic                w_is_acc;

    always_comb begin
        w_vld     = r_rd_used ? r_rd_row.vld : '0;
        w_hit     = 1'b0;
        w_hit_pos = '0;
        // Scan from the top so the lowest matching way wins
        for (int i = MAX_WAYS - 1; i >= 0; i--) begin
            if ((i < int'(w_ways)) && w_vld[i] && (r_rd_row.tags[i] == r_tag)) begin
                w_hit     = 1'b1;
                w_hit_pos = WAY_W'(i);
            end
        end
        w_is_acc = (r_cmd != CMD_FETCH);
        w_pos    = w_hit ? w_hit_pos : w_last_way;
        w_evict  = !w_hit && w_vld[w_last_way];

        // Shift ways below the hit (or the victim) down by one, new tag in front
        for (int i = 0; i < MAX_WAYS; i++) begin
            if (i == 0) begin
                w_wr_row.tags[i] = r_tag;
                w_wr_row.vld[i]  = 1'b1;
            end else if (i <= int'(w_pos)) begin
                w_wr_row.tags[i] = r_rd_row.tags[i-1];
                w_wr_row.vld[i]  = w_vld[i-1];
            end else begin
                w_wr_row.tags[i] = r_rd_row.tags[i];
                w_wr_row.vld[i]  = w_vld[i];
            end
        end
    end

    // ------------------------------------------------------------------
    // Saturating counters and result register
    // ------------------------------------------------------------------
    logic [31:0] r_hit_cnt;
    logic [31:0] r_miss_cnt;
    logic [31:0] r_evict_cnt;
    logic [31:0] n_hit_cnt;
    logic [31:0] n_miss_cnt;
    logic [31:0] n_evict_cnt;
    logic        w_r_hit;
    logic        w_r_miss;
    logic        w_r_evict;
    logic        w_r_mod;

    always_comb begin
        w_r_hit     = w_is_acc && w_hit;
        w_r_miss    = w_is_acc && !w_hit;
        w_r_evict   = w_is_acc && w_evict;
        w_r_mod     = (r_cmd == CMD_MODIFY);
        // A modify also counts its write as a hit
        n_hit_cnt   = sat_inc(sat_inc(r_hit_cnt, w_r_hit), w_r_mod);
        n_miss_cnt  = sat_inc(r_miss_cnt, w_r_miss);
        n_evict_cnt = sat_inc(r_evict_cnt, w_r_evict);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit_cnt   <= '0;
            r_miss_cnt  <= '0;
            r_evict_cnt <= '0;
            o_out_valid <= 1'b0;
        end else begin
            if (w_finish) begin
                r_hit_cnt   <= n_hit_cnt;
                r_miss_cnt  <= n_miss_cnt;
                r_evict_cnt <= n_evict_cnt;
                o_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                o_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            o_out_data.was_hit          <= w_r_hit;
            o_out_data.was_miss         <= w_r_miss;
            o_out_data.was_eviction     <= w_r_evict;
            o_out_data.modify_write_hit <= w_r_mod;
            o_out_data.hit_total        <= n_hit_cnt;
            o_out_data.miss_total       <= n_miss_cnt;
            o_out_data.eviction_total   <= n_evict_cnt;
        end
    end

endmodule

@@ hdl/lru_chk.sv @@
// Port-level checker for the LRU cache model top level, attached by bind.
// Depends on lru_pkg and lru_set_assoc_cache_model_top_defines.svh.
`timescale 1ns / 1ps
`include "lru_set_assoc_cache_model_top_defines.svh"

module lru_chk
    import lru_pkg::*;
(
    input logic                  i_clk,
    input logic                  i_rst_n,
    input logic                  i_in_valid,
    input logic                  o_in_ready,
    input t_in                   i_in_data,
    input logic                  o_out_valid,
    input logic                  i_out_ready,
    input t_out                  o_out_data,
    input logic                  i_cfg_we,
    input logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input logic [CFG_DATA_W-1:0] i_cfg_data
);

    // A result is a hit or a miss, never both
    `LRU_ASSERT_IMPL(a_hit_miss_excl, i_clk, i_rst_n, o_out_valid, !(o_out_data.was_hit && o_out_data.was_miss))
    // An eviction only comes with a miss
    `LRU_ASSERT_IMPL(a_evict_on_miss, i_clk, i_rst_n, o_out_valid && o_out_data.was_eviction, o_out_data.was_miss)
    // One transaction in flight: busy in the cycle after an accept
    `LRU_ASSERT_NEXT(a_busy_after_acc, i_clk, i_rst_n, i_in_valid && o_in_ready, !o_in_ready)
    // A stalled result holds
    `LRU_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

endmodule

bind lru_set_assoc_cache_model_top lru_chk u_lru_chk (.*);

@@ verif/lru_cache_check_pkg.sv @@
// Scoreboard for the LRU cache model testbench: a tag-only cache predictor
// plus an in-order queue of expected results. Depends on lru_pkg.
`timescale 1ns / 1ps

package lru_cache_check_pkg;
    import lru_pkg::*;

    class lru_cache_scoreboard;
        logic [TAG_W-1:0] tag_mem  [NUM_SETS*MAX_WAYS];
        bit               line_vld [NUM_SETS*MAX_WAYS];
        bit [31:0]        hit_cnt;
        bit [31:0]        miss_cnt;
        bit [31:0]        evict_cnt;
        int unsigned      eff_set_bits;
        int unsigned      eff_ways;
        int unsigned      eff_off_bits;
        t_out             result_q[$];
        int unsigned      accesses;
        int unsigned      checked;
        int unsigned      mismatches;

        function new();
            foreach (line_vld[i]) line_vld[i] = 1'b0;
            hit_cnt    = '0;
            miss_cnt   = '0;
            evict_cnt  = '0;
            accesses   = 0;
            checked    = 0;
            mismatches = 0;
            configure(6'd0, 6'd1, 6'd0);
        endfunction

        // Apply register writes, clamping to what the hardware supports.
        function void configure(bit [5:0] set_raw, bit [5:0] way_raw, bit [5:0] off_raw);
            bit [2:0] s3;
            bit [3:0] w4;
            s3 = set_raw[2:0];
            w4 = way_raw[3:0];
            eff_set_bits = (s3 > MAX_SET_BITS) ? MAX_SET_BITS : s3;
            eff_ways     = (w4 == 0) ? 1 : ((w4 > MAX_WAYS) ? MAX_WAYS : w4);
            eff_off_bits = (off_raw > MAX_OFFSET_BITS) ? MAX_OFFSET_BITS : off_raw;
        endfunction

        function bit [31:0] sat_inc(bit [31:0] v);
            return (v == 32'hFFFF_FFFF) ? v : v + 32'd1;
        endfunction

        // Look the access up, update the set's recency order and queue the result; a fetch only queues the totals.
        function void note_access(t_in acc);
            t_out             r;
            logic [TAG_W-1:0] tg;
            int unsigned      set_no;
            int unsigned      base;
            int unsigned      pos;
            int unsigned      i;
            r = '0;
            accesses++;
            if (acc.command != CMD_FETCH) begin
                set_no = int'((acc.address >> eff_off_bits)
                              & ((64'd1 << eff_set_bits) - 64'd1));
                tg     = acc.address >> (eff_off_bits + eff_set_bits);
                base   = set_no * MAX_WAYS;
                pos    = eff_ways;
                for (i = 0; i < eff_ways; i++) begin
                    if (pos == eff_ways && line_vld[base+i] && tag_mem[base+i] == tg)
                        pos = i;
                end
                if (pos < eff_ways) begin
                    r.was_hit = 1'b1;
                    hit_cnt   = sat_inc(hit_cnt);
                end else begin
                    r.was_miss = 1'b1;
                    miss_cnt   = sat_inc(miss_cnt);
                    if (line_vld[base+eff_ways-1]) begin
                        r.was_eviction = 1'b1;
                        evict_cnt      = sat_inc(evict_cnt);
                    end
                    pos = eff_ways - 1;
                end
                for (i = pos; i > 0; i--) begin
                    tag_mem[base+i]  = tag_mem[base+i-1];
                    line_vld[base+i] = line_vld[base+i-1];
                end
                tag_mem[base]  = tg;
                line_vld[base] = 1'b1;
                if (acc.command == CMD_MODIFY) begin
                    r.modify_write_hit = 1'b1;
                    hit_cnt            = sat_inc(hit_cnt);
                end
            end
            r.hit_total      = hit_cnt;
            r.miss_total     = miss_cnt;
            r.eviction_total = evict_cnt;
            result_q.push_back(r);
        endfunction

        function void check_result(t_out got);
            t_out want;
            bit   bad;
            checked++;
            if (result_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t: result with nothing outstanding: flags %b%b%b%b", $time,
                             got.was_hit, got.was_miss, got.was_eviction, got.modify_write_hit);
                return;
            end
            want = result_q.pop_front();
            bad  = (got.was_hit !== want.was_hit) || (got.was_miss !== want.was_miss)
                || (got.was_eviction !== want.was_eviction)
                || (got.modify_write_hit !== want.modify_write_hit)
                || (got.hit_total !== want.hit_total) || (got.miss_total !== want.miss_total)
                || (got.eviction_total !== want.eviction_total);
            if (bad) begin
                mismatches++;
                if (mismatches <= 10) begin
                    $display("%0t: result %0d hit/miss/evict/mod exp %b%b%b%b got %b%b%b%b",
                             $time, checked, want.was_hit, want.was_miss, want.was_eviction,
                             want.modify_write_hit, got.was_hit, got.was_miss,
                             got.was_eviction, got.modify_write_hit);
                    $display("    totals exp %0d/%0d/%0d got %0d/%0d/%0d",
                             want.hit_total, want.miss_total, want.eviction_total,
                             got.hit_total, got.miss_total, got.eviction_total);
                end
            end
        endfunction

        function int pending();
            return result_q.size();
        endfunction

        function void flush_leftover();
            if (result_q.size() != 0) begin
                $display("%0d expected results never arrived", result_q.size());
                mismatches += result_q.size();
                result_q.delete();
            end
        endfunction
    endclass

endpackage

@@ verif/tb_top.sv @@
// Testbench top for the LRU set-associative cache model: drives accesses and
// register writes, predicts results through the scoreboard class.
// Depends on lru_pkg and lru_cache_check_pkg.
`timescale 1ns / 1ps

module tb_top;
    import lru_pkg::*;
    import lru_cache_check_pkg::*;

    localparam int PHASE_ITEMS = 50;
    localparam int NUM_PHASES  = 9;
    localparam int POOL_SIZE   = 12;

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  acc_valid = 1'b0;
    logic                  acc_ready;
    t_in                   acc_data  = '0;
    logic                  res_valid;
    logic                  res_ready = 1'b0;
    t_out                  res_data;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx   = CFG_SET_INDEX_BITS;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;

    lru_cache_scoreboard sb = new();

    // Idling is switched per stretch of stimulus; off for the closing phase.
    bit          idle_on    = 1'b1;
    int          stall_left = 0;
    logic [63:0] tag_pool [POOL_SIZE];
    int          settings_run = 1;

    // Register settings for the random phases: minimum, maximum, out of range,
    // zero ways, oversize offset, and write data with spare high bits set.
    bit [5:0] ph_sets [NUM_PHASES] = '{6'd0, 6'd6, 6'd7,  6'd3, 6'd1,  6'd6, 6'h3E, 6'd4, 6'd5};
    bit [5:0] ph_ways [NUM_PHASES] = '{6'd1, 6'd8, 6'd15, 6'd0, 6'd4,  6'd9, 6'h38, 6'd3, 6'd8};
    bit [5:0] ph_off  [NUM_PHASES] = '{6'd0, 6'd32, 6'd63, 6'd6, 6'd33, 6'd5, 6'h3F, 6'd0, 6'd12};

    always #5 clk = ~clk;

    lru_set_assoc_cache_model_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (acc_valid),
        .o_in_ready  (acc_ready),
        .i_in_data   (acc_data),
        .o_out_valid (res_valid),
        .i_out_ready (res_ready),
        .o_out_data  (res_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    // Check every result transaction at the rising edge it is taken.
    always @(posedge clk) begin
        if (rst_n && res_valid && res_ready)
            sb.check_result(res_data);
    end

    // Stall the result channel in bursts while idling is on.
    always @(negedge clk) begin
        if (stall_left > 0) begin
            res_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end else if (idle_on && $urandom_range(0, 5) == 0) begin
            res_ready  <= 1'b0;
            stall_left <= $urandom_range(0, 9);
        end else begin
            res_ready <= 1'b1;
        end
    end

    // Offer one access transaction and hold it until the block takes it.
    // Enter and leave at a falling edge; valid stays high for a follow-on item.
    task automatic send_access(input logic [1:0] cmd, input logic [63:0] addr);
        t_in item;
        item.command = cmd;
        item.address = addr;
        if (idle_on && $urandom_range(0, 3) == 0) begin
            acc_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(negedge clk);
        end
        acc_valid <= 1'b1;
        acc_data  <= item;
        @(posedge clk);
        while (!acc_ready) @(posedge clk);
        sb.note_access(item);
        @(negedge clk);
    endtask

    // Drop valid, wait for every outstanding result, then let the pipe settle.
    task automatic drain();
        acc_valid <= 1'b0;
        while (sb.pending() != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    // Write all three registers on consecutive cycles; the block is idle here.
    task automatic set_geometry(input bit [5:0] set_raw, input bit [5:0] way_raw,
                                input bit [5:0] off_raw);
        cfg_we   <= 1'b1;
        cfg_idx  <= CFG_SET_INDEX_BITS;
        cfg_data <= set_raw;
        @(negedge clk);
        cfg_idx  <= CFG_WAYS_IN_USE;
        cfg_data <= way_raw;
        @(negedge clk);
        cfg_idx  <= CFG_BLOCK_OFFSET_BITS;
        cfg_data <= off_raw;
        @(negedge clk);
        cfg_we   <= 1'b0;
        sb.configure(set_raw, way_raw, off_raw);
        settings_run++;
    endtask

    function automatic logic [1:0] pick_command();
        case ($urandom_range(0, 9))
            0, 1, 2: return CMD_LOAD;
            3, 4, 5: return CMD_STORE;
            6, 7, 8: return CMD_MODIFY;
            default: return CMD_FETCH;
        endcase
    endfunction

    // Build an address from a small tag pool and a few sets so that lines
    // get reused, pushed down the recency order and evicted.
    function automatic logic [63:0] pool_address(input int tag_span, input int set_span);
        logic [63:0] tg;
        logic [63:0] set_no;
        logic [63:0] off_mask;
        int unsigned s;
        int unsigned b;
        s        = sb.eff_set_bits;
        b        = sb.eff_off_bits;
        tg       = tag_pool[$urandom_range(0, tag_span - 1)];
        set_no   = 64'($urandom_range(0, set_span - 1)) & ((64'd1 << s) - 64'd1);
        off_mask = (64'd1 << b) - 64'd1;
        return (tg << (b + s)) | (set_no << b) | ({$urandom, $urandom} & off_mask);
    endfunction

    task automatic run_phase(input bit quiet_end);
        int k;
        int tag_span;
        int set_span;
        for (k = 0; k < PHASE_ITEMS; k++) begin
            // Leave one stretch of each phase free of idling on both sides.
            idle_on  = !quiet_end && !(k >= PHASE_ITEMS / 2 && k < PHASE_ITEMS / 2 + 12);
            tag_span = sb.eff_ways + 3;
            set_span = (sb.eff_set_bits < 2) ? (1 << sb.eff_set_bits) : 3;
            if ($urandom_range(0, 9) == 0)
                send_access(pick_command(), {$urandom, $urandom});
            else
                send_access(pick_command(), pool_address(tag_span, set_span));
        end
    endtask

    initial begin
        int p;
        for (p = 0; p < POOL_SIZE; p++)
            tag_pool[p] = (p < 4) ? 64'(p) : {$urandom, $urandom};
        repeat (10) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset settings: one set, one way, no offset bits.
        send_access(CMD_LOAD, 64'h0);
        send_access(CMD_LOAD, 64'h0);
        send_access(CMD_STORE, 64'h1);
        send_access(CMD_MODIFY, 64'h1);
        send_access(CMD_FETCH, '1);
        drain();

        // Four sets, two ways, 16-byte blocks; old lines are reread with the new split.
        set_geometry(6'd2, 6'd2, 6'd4);
        send_access(CMD_LOAD, 64'h0);
        send_access(CMD_STORE, 64'hF);
        send_access(CMD_MODIFY, 64'h40);
        send_access(CMD_LOAD, 64'h80);
        send_access(CMD_LOAD, 64'h10);
        send_access(CMD_LOAD, '1);
        send_access(CMD_STORE, '1);
        send_access(CMD_MODIFY, 64'h8000_0000_0000_0000);
        send_access(CMD_LOAD, 64'h7FFF_FFFF_FFFF_FFF0);
        send_access(CMD_FETCH, 64'h0);
        send_access(CMD_LOAD, 64'h0);
        send_access(CMD_MODIFY, 64'hC0);
        send_access(CMD_LOAD, 64'h40);
        drain();

        for (p = 0; p < NUM_PHASES; p++) begin
            set_geometry(ph_sets[p], ph_ways[p], ph_off[p]);
            run_phase(p == NUM_PHASES - 1);
            drain();
        end

        repeat (10) @(negedge clk);
        sb.flush_leftover();
        $display("Ran %0d accesses under %0d register settings: %0d hits, %0d misses, %0d evictions",
                 sb.accesses, settings_run, sb.hit_cnt, sb.miss_cnt, sb.evict_cnt);
        $display("Checked %0d results, %0d bad", sb.checked, sb.mismatches);
        if (sb.mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

    // Hard stop well beyond the slowest legal run.
    initial begin
        #2_000_000;
        $display("Timeout: stimulus or results stalled");
        $display("Mismatches found");
        $finish;
    end

endmodule

@@ sim.f @@
+incdir+hdl
hdl/lru_pkg.sv
hdl/lru_set_assoc_cache_model_top.sv
hdl/lru_chk.sv
verif/lru_cache_check_pkg.sv
verif/tb_top.sv
